[hdl/wmnaf_pkg.sv]
package wmnaf_pkg;

   localparam int CFG_W          = 3;
   localparam int DIGIT_W        = 8;
   localparam int MAX_WINDOW_DEF = 7;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 3'd4;

   // input queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      ITEM_BIT,
      ITEM_FINAL
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          magnitude_bit;
      logic          negative;
   } item_type;

   typedef enum logic [0:0] {
      BK_RUN,
      BK_DRAIN
   } back_state_type;

endpackage

[hdl/wmnaf_scalar_recoder_top.sv]
// modified width-w naf recoder
// req_ channel: one word per scalar bit, magnitude least significant first, with the
// scalar's sign (taken from the first word of each scalar) and a final flag on the top
// set bit; a zero scalar is a single final word carrying a 0 bit.
// rsp_ channel: signed digits, least significant first; one per word once the window
// is full, the rest after the final word; rsp_last_digit marks a scalar's closing digit.
// csr_ channel: window width w, reset value 4, 0 acts as 1; csr_ready is always high.
// to be written only while idle (not enforced); any write drops a scalar in flight.
// the front has a two-entry queue; the back consumes one word per cycle unless stalled.
// an accepted word is written to the queue; the back pops it and registers its digit
// in the output register, which holds it until the receiver takes it.
// throughput: one bit per cycle sustained while rsp_stall is low; the first w+1 bits of
// a scalar only fill the window. a final word occupies the back while up to w+2
// top-window digits drain one per cycle unless stalled; the queue fills and stalls req_.
// rsp_stall holds the output register and, once it backs up, stops the back, then
// the queue, then req_.
// reset clears the queue, the window and the output valid flag, and sets w to 4.
module wmnaf_scalar_recoder_top #(
   parameter int MAX_WINDOW = wmnaf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_magnitude_bit,
   input  logic                                 req_negative,
   input  logic                                 req_final_bit,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wmnaf_pkg::DIGIT_W-1:0] rsp_digit,
   output logic                                 rsp_last_digit,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wmnaf_pkg::CFG_W-1:0]          csr_window_width
);
   import wmnaf_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;

   wmnaf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_magnitude_bit (req_magnitude_bit),
      .req_negative      (req_negative),
      .req_final_bit     (req_final_bit),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   wmnaf_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_width (csr_window_width),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit        (rsp_digit),
      .rsp_last_digit   (rsp_last_digit)
   );

endmodule

[hdl/wmnaf_front.sv]
module wmnaf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_magnitude_bit,
   input  logic                req_negative,
   input  logic                req_final_bit,
   output logic                q_valid,
   output wmnaf_pkg::item_type q_item,
   input  logic                q_pop
);
   import wmnaf_pkg::*;

   item_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   item_type           item_in;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   // classify the word: an ordinary bit or the one that ends the scalar
   always_comb begin
      item_in.kind          = req_final_bit ? ITEM_FINAL : ITEM_BIT;
      item_in.magnitude_bit = req_magnitude_bit;
      item_in.negative      = req_negative;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push lost");

endmodule

[hdl/wmnaf_back.sv]
module wmnaf_back #(
   parameter int MAX_WINDOW = wmnaf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  wmnaf_pkg::item_type                  q_item,
   output logic                                 q_pop,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wmnaf_pkg::CFG_W-1:0]          csr_window_width,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wmnaf_pkg::DIGIT_W-1:0] rsp_digit,
   output logic                                 rsp_last_digit
);
   import wmnaf_pkg::*;

   localparam int WIN_W  = MAX_WINDOW + 2;
   localparam int SW     = WIN_W + 1;
   localparam int FILL_W = $clog2(MAX_WINDOW + 2);

   logic [CFG_W-1:0]          width_ff, width_in;
   logic [WIN_W-1:0]          window_ff, window_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      sign_ff, sign_in;
   back_state_type            state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [CFG_W-1:0]     w_eff;
   logic                 cfg_write;
   logic                 out_free;
   logic                 out_load;
   logic                 fill_full;
   logic                 sign_use;
   logic                 sign_dig;
   logic signed [SW-1:0] d_run, d_top, d_sel;
   logic signed [SW-1:0] d_signed;
   logic [WIN_W-1:0]     v_run_sh, v_top_sh, v_next;
   logic [WIN_W-1:0]     bit_in;

   // one digit out of the window, window shifted right by one
   function automatic void take_digit(
      input  logic [WIN_W-1:0]     v,
      input  logic [CFG_W-1:0]     w,
      input  logic                 top,
      output logic signed [SW-1:0] d,
      output logic [WIN_W-1:0]     v_sh
   );
      logic signed [SW-1:0] vs;
      logic signed [SW-1:0] bitv;
      logic signed [SW-1:0] rest;
      vs   = signed'({1'b0, v});
      bitv = SW'(1) << w;
      d    = '0;
      if (v[0]) begin
         if ((vs & bitv) != '0) begin
            d = top ? (vs & (bitv - SW'(1))) : (vs - (bitv <<< 1));
         end else begin
            d = vs;
         end
      end
      rest = vs - d;
      v_sh = rest[WIN_W:1];
   endfunction

   assign cfg_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (width_ff > CFG_W'(MAX_WINDOW)) begin
         w_eff = CFG_W'(MAX_WINDOW);
      end else begin
         w_eff = width_ff;
      end
   end

   assign fill_full = (fill_ff > FILL_W'(w_eff));
   assign sign_use  = (fill_ff == '0) ? q_item.negative : sign_ff;

   always_comb begin
      take_digit(window_ff, w_eff, 1'b0, d_run, v_run_sh);
      take_digit(window_ff, w_eff, 1'b1, d_top, v_top_sh);
   end

   always_comb begin
      width_in     = width_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      sign_in      = sign_ff;
      state_in     = state_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      d_sel        = '0;
      rsp_last_in  = 1'b0;
      v_next       = window_ff;
      bit_in       = '0;
      sign_dig     = sign_ff;

      unique case (state_ff)
         BK_RUN: begin
            sign_dig = sign_use;
            if (q_valid && out_free) begin
               q_pop   = 1'b1;
               sign_in = sign_use;
               if (fill_full) begin
                  bit_in   = WIN_W'(q_item.magnitude_bit) << w_eff;
                  v_next   = v_run_sh + bit_in;
                  out_load = 1'b1;
                  d_sel    = d_run;
               end else begin
                  bit_in  = WIN_W'(q_item.magnitude_bit) << fill_ff;
                  v_next  = window_ff | bit_in;
                  fill_in = FILL_W'(fill_ff + 1'b1);
               end
               window_in = v_next;
               if (q_item.kind == ITEM_FINAL) begin
                  if (v_next == '0) begin
                     // nothing left: the digit just taken, or a lone zero, closes it
                     out_load    = 1'b1;
                     rsp_last_in = 1'b1;
                     window_in   = '0;
                     fill_in     = '0;
                     sign_in     = 1'b0;
                  end else begin
                     state_in = BK_DRAIN;
                  end
               end
            end
         end
         BK_DRAIN: begin
            if (out_free) begin
               out_load  = 1'b1;
               d_sel     = d_top;
               window_in = v_top_sh;
               if (v_top_sh == '0) begin
                  rsp_last_in = 1'b1;
                  fill_in     = '0;
                  sign_in     = 1'b0;
                  state_in    = BK_RUN;
               end
            end
         end
         default: state_in = BK_RUN;
      endcase

      // a width write drops any scalar in flight
      if (cfg_write) begin
         width_in  = csr_window_width;
         window_in = '0;
         fill_in   = '0;
         sign_in   = 1'b0;
         state_in  = BK_RUN;
      end

      d_signed     = sign_dig ? -d_sel : d_sel;
      rsp_digit_in = DIGIT_W'(d_signed);
      rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         window_ff    <= '0;
         fill_ff      <= '0;
         sign_ff      <= 1'b0;
         state_ff     <= BK_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         sign_ff      <= sign_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_digit_ff <= rsp_digit_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

   a_drain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DRAIN) |-> (window_ff != '0))
      else $error("draining an empty window");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fill_ff} <= (FILL_W + 1)'(w_eff) + 1'b1))
      else $error("window overfilled");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> (window_ff == '0 && fill_ff == '0 && state_ff == BK_RUN))
      else $error("scan state left after last digit");

   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DRAIN) |-> !q_pop)
      else $error("item taken while draining");

endmodule

[bench/testbench.sv]
class naf_digit_predictor;

   typedef struct {
      logic signed [wmnaf_pkg::DIGIT_W-1:0] digit;
      logic                                 last;
   } digit_word_type;

   logic [wmnaf_pkg::CFG_W-1:0] width_setting;
   logic [8:0]                  window_bits;
   logic [3:0]                  bits_filled;
   logic                        sign_latch;
   digit_word_type              awaited_digits[$];
   int                          mismatch_count;

   function new();
      width_setting  = wmnaf_pkg::WIDTH_RESET;
      mismatch_count = 0;
      clear_scan();
   endfunction

   function void clear_scan();
      window_bits = '0;
      bits_filled = '0;
      sign_latch  = 1'b0;
   endfunction

   function void set_width(input logic [wmnaf_pkg::CFG_W-1:0] w);
      width_setting = w;
      clear_scan();
   endfunction

   function int active_width();
      int w;
      w = width_setting;
      if (w < 1) w = 1;
      if (w > wmnaf_pkg::MAX_WINDOW_DEF) w = wmnaf_pkg::MAX_WINDOW_DEF;
      return w;
   endfunction

   function int pending();
      return awaited_digits.size();
   endfunction

   // one digit off the bottom of the window; top_rule keeps the top window positive
   function logic signed [wmnaf_pkg::DIGIT_W-1:0] pop_digit(input int w, input bit top_rule);
      int bitv;
      int v;
      int d;
      bitv = 1 << w;
      v    = window_bits;
      d    = 0;
      if (v[0]) begin
         if ((v & bitv) != 0) d = top_rule ? (v & (bitv - 1)) : (v - 2 * bitv);
         else d = v;
         v = v - d;
      end
      window_bits = 9'((v >> 1) & 'h1FF);
      if (sign_latch) d = -d;
      return d[wmnaf_pkg::DIGIT_W-1:0];
   endfunction

   function void take_scalar_bit(input logic b, input logic neg, input logic fin);
      digit_word_type fresh[$];
      digit_word_type entry;
      int             w;
      int             sum;
      w = active_width();
      if (bits_filled == 0) sign_latch = neg;
      if (bits_filled >= w + 1) begin
         entry.digit = pop_digit(w, 1'b0);
         entry.last  = 1'b0;
         fresh.push_back(entry);
         sum         = int'(window_bits) + (int'(b) << w);
         window_bits = sum[8:0];
      end else begin
         window_bits = window_bits | (9'(b) << bits_filled[2:0]);
         bits_filled = bits_filled + 4'd1;
      end
      if (fin) begin
         for (int i = 0; i < wmnaf_pkg::MAX_WINDOW_DEF + 2 && window_bits != 0; i++) begin
            entry.digit = pop_digit(w, 1'b1);
            entry.last  = 1'b0;
            fresh.push_back(entry);
         end
         // zero scalar still closes with a single zero digit
         if (fresh.size() == 0) begin
            entry.digit = '0;
            entry.last  = 1'b0;
            fresh.push_back(entry);
         end
         fresh[fresh.size()-1].last = 1'b1;
         clear_scan();
      end
      foreach (fresh[k]) awaited_digits.push_back(fresh[k]);
   endfunction

   task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   task compare_digit(input logic signed [wmnaf_pkg::DIGIT_W-1:0] digit, input logic last);
      digit_word_type want;
      if (awaited_digits.size() == 0) begin
         report_mismatch($sformatf("digit %0d last %0b with nothing awaited", digit, last));
      end else begin
         want = awaited_digits.pop_front();
         if (digit !== want.digit)
            report_mismatch($sformatf("digit %0d, wanted %0d", digit, want.digit));
         if (last !== want.last)
            report_mismatch($sformatf("last_digit %0b, wanted %0b", last, want.last));
      end
   endtask

endclass

module testbench;

   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_WORDS    = 38;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_magnitude_bit;
   logic                                 req_negative;
   logic                                 req_final_bit;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [wmnaf_pkg::DIGIT_W-1:0] rsp_digit;
   logic                                 rsp_last_digit;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [wmnaf_pkg::CFG_W-1:0]          csr_window_width;

   naf_digit_predictor predictor = new();

   bit   calm = 1'b0;
   bit   hold_off_pending = 1'b0;
   int   words_sent = 0;
   int   idle_run;
   logic [wmnaf_pkg::CFG_W-1:0] width_plan [8];

   wmnaf_scalar_recoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_magnitude_bit(req_magnitude_bit),
      .req_negative     (req_negative),
      .req_final_bit    (req_final_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit        (rsp_digit),
      .rsp_last_digit   (rsp_last_digit),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_width (csr_window_width)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) predictor.set_width(csr_window_width);
         if (req_valid && !req_stall)
            predictor.take_scalar_bit(req_magnitude_bit, req_negative, req_final_bit);
         if (rsp_valid && !rsp_stall) predictor.compare_digit(rsp_digit, rsp_last_digit);
      end
   end

   // receiver: random stalls, plus one long hold-off so the queue backs up
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
         end
      end
   end

   initial begin
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_word(input logic b, input logic neg, input logic fin);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_magnitude_bit <= b;
      req_negative      <= neg;
      req_final_bit     <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // sign only counts on the first word, so later words carry noise there
   task automatic send_bits(input logic [31:0] bits, input int count, input logic neg,
                            input bit closes);
      for (int i = 0; i < count; i++)
         send_word(bits[i], (i == 0) ? neg : 1'($urandom_range(0, 1)),
                   closes && (i == count - 1));
   endtask

   task automatic send_scalar(input logic [31:0] magnitude, input logic neg);
      int count;
      count = 1;
      for (int i = 0; i < 32; i++) if (magnitude[i]) count = i + 1;
      send_bits(magnitude, count, neg, 1'b1);
   endtask

   task automatic send_random_scalar();
      int          kind;
      int          len;
      logic [31:0] bits;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         bits = $urandom & ((32'd1 << len) - 32'd1);
         bits[len-1] = 1'b1;
         send_bits(bits, len, 1'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 92) begin
         // closing word with a zero bit after others
         len  = $urandom_range(2, 10);
         bits = $urandom & ((32'd1 << (len - 1)) - 32'd1);
         send_bits(bits, len, 1'($urandom_range(0, 1)), 1'b1);
      end else begin
         send_scalar(32'd0, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [wmnaf_pkg::CFG_W-1:0] w);
      csr_valid        <= 1'b1;
      csr_window_width <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int start_count;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_magnitude_bit <= 1'b0;
      req_negative      <= 1'b0;
      req_final_bit     <= 1'b0;
      csr_valid         <= 1'b0;
      csr_window_width  <= '0;
      width_plan = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, window width from reset
      send_scalar(32'd0, 1'b0);
      send_scalar(32'd0, 1'b1);
      send_scalar(32'd1, 1'b0);
      send_scalar(32'd11, 1'b1);
      send_bits(32'b011, 3, 1'b0, 1'b1);
      send_scalar(32'h3F, 1'b0);
      // scalar left open, then dropped by the width write
      send_bits(32'b101, 3, 1'b1, 1'b0);
      settle_block();
      write_width(3'd7);
      send_scalar(32'd127, 1'b1);
      send_scalar(32'hFF, 1'b0);

      foreach (width_plan[p]) begin
         if (p != 0) begin
            settle_block();
            write_width(width_plan[p]);
         end
         calm = (p == 4);
         if (p == 2) hold_off_pending = 1'b1;
         start_count = words_sent;
         while (words_sent - start_count < PHASE_WORDS) send_random_scalar();
         if ($urandom_range(0, 1) == 1)
            send_bits($urandom, $urandom_range(1, 4), 1'($urandom_range(0, 1)), 1'b0);
         calm = 1'b0;
      end

      settle_block();
      if (predictor.mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
